@@ rtl/bhc_pkg.sv @@
// Shared types, codes, reset values and sector tables for the hall commutator.
// No dependencies; imported by every module in rtl/.
package bhc_pkg;

  // Event codes carried in the action field
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_HALL_A = 3'd1;
  localparam logic [2:0] ACT_HALL_B = 3'd2;
  localparam logic [2:0] ACT_HALL_C = 3'd3;
  localparam logic [2:0] ACT_SPEED  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_STALL_LIMIT    = 3'd0;
  localparam logic [2:0] REG_COMMAND_OFFSET = 3'd1;
  localparam logic [2:0] REG_MIN_COMMAND    = 3'd2;
  localparam logic [2:0] REG_KICK_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_COMPARE_GAP    = 3'd4;

  // Phase codes and low-side switch bits
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_U    = 2'd1;
  localparam logic [1:0] PH_V    = 2'd2;
  localparam logic [1:0] PH_W    = 2'd3;
  localparam logic [2:0] LO_NONE = 3'b000;
  localparam logic [2:0] LO_U    = 3'b001;
  localparam logic [2:0] LO_V    = 3'b010;
  localparam logic [2:0] LO_W    = 3'b100;

  // Hall-edge sectors
  localparam logic [2:0] SEC_NONE = 3'd0;
  localparam logic [2:0] SEC_1    = 3'd1;
  localparam logic [2:0] SEC_2    = 3'd2;
  localparam logic [2:0] SEC_3    = 3'd3;
  localparam logic [2:0] SEC_4    = 3'd4;
  localparam logic [2:0] SEC_5    = 3'd5;
  localparam logic [2:0] SEC_6    = 3'd6;

  // Reset values
  localparam logic [7:0] STALL_LIMIT_RST    = 8'd100;
  localparam logic [7:0] COMMAND_OFFSET_RST = 8'd250;
  localparam logic [7:0] MIN_COMMAND_RST    = 8'd190;
  localparam logic [7:0] KICK_THRESHOLD_RST = 8'd225;
  localparam logic [7:0] COMPARE_GAP_RST    = 8'd10;
  localparam logic [7:0] CMP_A_RST          = 8'd220;
  localparam logic [7:0] CMP_B_RST          = 8'd210;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] hall_bits;
    logic [7:0] speed_byte;
  } item_in_t;

  typedef struct packed {
    logic [1:0] high_side;
    logic [2:0] low_side_mask;
    logic [7:0] compare_a;
    logic [7:0] compare_b;
    logic       running;
    logic [7:0] revolution_count;
  } item_out_t;

  typedef struct packed {
    logic [7:0] stall_limit;
    logic [7:0] command_offset;
    logic [7:0] min_command;
    logic [7:0] kick_threshold;
    logic [7:0] compare_gap;
  } cfg_t;

  typedef struct packed {
    logic [7:0] stall_count;
    logic       run_flag;
    logic [1:0] high_sel;
    logic [2:0] low_mask;
    logic [2:0] start_sector;
    logic [7:0] revolutions;
    logic [7:0] speed_level;
    logic [7:0] cmp_a_reg;
    logic [7:0] cmp_b_reg;
  } state_t;

  function automatic logic [1:0] sector_high(input logic [2:0] sec);
    logic [1:0] ph;
    case (sec)
      SEC_1:   ph = PH_V;
      SEC_2:   ph = PH_W;
      SEC_3:   ph = PH_W;
      SEC_4:   ph = PH_U;
      SEC_5:   ph = PH_V;
      SEC_6:   ph = PH_U;
      default: ph = PH_NONE;
    endcase
    return ph;
  endfunction

  function automatic logic [2:0] sector_low(input logic [2:0] sec);
    logic [2:0] lo;
    case (sec)
      SEC_1:   lo = LO_U;
      SEC_2:   lo = LO_V;
      SEC_3:   lo = LO_U;
      SEC_4:   lo = LO_W;
      SEC_5:   lo = LO_W;
      SEC_6:   lo = LO_V;
      default: lo = LO_NONE;
    endcase
    return lo;
  endfunction

endpackage

@@ rtl/bhc_cfg_regs.sv @@
// Configuration register file of the hall commutator.
// Depends on bhc_pkg (cfg_t, register indexes, reset values).
module bhc_cfg_regs import bhc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_limit    <= STALL_LIMIT_RST;
      cfg.command_offset <= COMMAND_OFFSET_RST;
      cfg.min_command    <= MIN_COMMAND_RST;
      cfg.kick_threshold <= KICK_THRESHOLD_RST;
      cfg.compare_gap    <= COMPARE_GAP_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STALL_LIMIT:    cfg.stall_limit    <= cfg_data;
        REG_COMMAND_OFFSET: cfg.command_offset <= cfg_data;
        REG_MIN_COMMAND:    cfg.min_command    <= cfg_data;
        REG_KICK_THRESHOLD: cfg.kick_threshold <= cfg_data;
        REG_COMPARE_GAP:    cfg.compare_gap    <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule

@@ rtl/bhc_step.sv @@
// Next-state logic for one event of the hall commutator.
// Depends on bhc_pkg (item, state and config types, sector tables).
module bhc_step import bhc_pkg::*; (
  input  item_in_t item,
  input  state_t   cur,
  input  cfg_t     cfg,
  output state_t   nxt
);

  logic [7:0] cmd_raw;
  logic [7:0] cmd;
  logic [7:0] stall_inc;
  logic       stalled;
  logic [2:0] edge_sec;
  logic       kick_pos_ok;

  assign cmd_raw     = cfg.command_offset - cur.speed_level;
  assign cmd         = (cmd_raw < cfg.min_command) ? cfg.min_command : cmd_raw;
  assign stall_inc   = (cur.stall_count < cfg.stall_limit) ? cur.stall_count + 8'd1
                                                           : cur.stall_count;
  assign stalled     = (stall_inc >= cfg.stall_limit);
  assign kick_pos_ok = (item.hall_bits != SEC_NONE) && (item.hall_bits != 3'd7);

  // Sector picked by the edge direction of the sensor that moved
  always_comb begin
    case (item.action)
      ACT_HALL_A: edge_sec = item.hall_bits[0] ? SEC_3 : SEC_4;
      ACT_HALL_B: edge_sec = item.hall_bits[1] ? SEC_6 : SEC_1;
      ACT_HALL_C: edge_sec = item.hall_bits[2] ? SEC_5 : SEC_2;
      default:    edge_sec = SEC_NONE;
    endcase
  end

  always_comb begin
    nxt = cur;
    case (item.action)
      ACT_TICK: begin
        if (cur.run_flag) begin
          nxt.cmp_a_reg = cmd;
          nxt.cmp_b_reg = cmd - cfg.compare_gap;
        end else begin
          nxt.high_sel = PH_U;
          nxt.low_mask = cur.low_mask & LO_U;
        end
        nxt.stall_count = stall_inc;
        nxt.run_flag    = !stalled;
        // stopped and command low enough: kick from present hall position
        if (stalled && (cmd < cfg.kick_threshold)) begin
          if (kick_pos_ok) begin
            nxt.low_mask     = nxt.low_mask | sector_low(item.hall_bits);
            nxt.high_sel     = sector_high(item.hall_bits);
            nxt.start_sector = item.hall_bits;
          end
          nxt.run_flag    = 1'b1;
          nxt.stall_count = 8'd0;
        end
      end
      ACT_HALL_A, ACT_HALL_B, ACT_HALL_C: begin
        nxt.stall_count = 8'd0;
        nxt.high_sel    = sector_high(edge_sec);
        nxt.low_mask    = sector_low(edge_sec);
        if (cur.start_sector == edge_sec) begin
          nxt.revolutions = cur.revolutions + 8'd1;
        end
      end
      ACT_SPEED: begin
        nxt.speed_level = item.speed_byte;
      end
      default: ;  // unused codes leave the state alone
    endcase
  end

endmodule

@@ rtl/bldc_hall_commutator_core.sv @@
// Top level of the six-step hall commutator: input register, step logic, result register.
// Depends on bhc_pkg, bhc_cfg_regs and bhc_step.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | input     | in_valid/in_ready  | in_data  (item_in_t: action, halls, byte)
//  out     | output    | out_valid/out_ready| out_data (item_out_t: drive, compares, ...)
//  cfg     | input     | cfg_write          | cfg_index, cfg_data (no read-back)
//
// Flow: one transaction in per clock while in_ready is high; each result passes
//   through the input register, then the result register through one level of
//   step logic that updates the motor state.
// Reset: rst (sync, high) loads the register reset values and empties both stages.
// Stalls: with out_ready low a full result register holds and the input register
//   still fills; in_ready drops only when both are full and out_ready is low.
module bldc_hall_commutator_core import bhc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  item_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output item_out_t out_data,
  input  logic      cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t     cfg;
  state_t   state;
  state_t   state_next;
  item_in_t s1_item;
  logic     s1_valid;
  logic     adv;    // stage-1 transaction moves into the result register

  bhc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bhc_step u_step (
    .item (s1_item),
    .cur  (state),
    .cfg  (cfg),
    .nxt  (state_next)
  );

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // Motor state: committed when the event leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      state.stall_count  <= 8'd0;
      state.run_flag     <= 1'b0;
      state.high_sel     <= PH_NONE;
      state.low_mask     <= LO_NONE;
      state.start_sector <= SEC_NONE;
      state.revolutions  <= 8'd0;
      state.speed_level  <= 8'd0;
      state.cmp_a_reg    <= CMP_A_RST;
      state.cmp_b_reg    <= CMP_B_RST;
    end else if (adv) begin
      state <= state_next;
    end
  end

  // Result register: shows the state after the event
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      out_data.high_side        <= state_next.high_sel;
      out_data.low_side_mask    <= state_next.low_mask;
      out_data.compare_a        <= state_next.cmp_a_reg;
      out_data.compare_b        <= state_next.cmp_b_reg;
      out_data.running          <= state_next.run_flag;
      out_data.revolution_count <= state_next.revolutions;
    end
  end

  // in_ready drops only with both stages full and the sink stalled
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("in_ready low without full pipeline and stalled output");

  // every transaction leaving stage 1 lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("result register empty after advance");

  // motor state moves only with a transaction
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(state))
    else $error("motor state changed without a transaction");

  // revolution count steps by at most one per event
  a_rev_step: assert property (@(posedge clk) disable iff (rst)
    adv |=> ((state.revolutions == $past(state.revolutions)) ||
             (state.revolutions == $past(state.revolutions) + 8'd1)))
    else $error("revolution count jumped");

endmodule
